// File: rtl/text_buffer_edit_engine_top_macros.svh
// Assertion macros for the text buffer edit engine.
`ifndef TEXT_BUFFER_EDIT_ENGINE_TOP_MACROS_SVH
`define TEXT_BUFFER_EDIT_ENGINE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/tbe_pkg.sv
// Package with codes and types of the text buffer edit engine.
package tbe_pkg;
  localparam int unsigned BufferBytesDefault = 2048;
  localparam int unsigned FieldW = 11;

  localparam logic [2:0] OpKey    = 3'd0;
  localparam logic [2:0] OpRead   = 3'd1;
  localparam logic [2:0] OpClear  = 3'd2;
  localparam logic [2:0] OpAppend = 3'd3;
  localparam logic [2:0] OpSaved  = 3'd4;

  localparam logic [7:0] KeyBs     = 8'd8;
  localparam logic [7:0] KeyNl     = 8'd10;
  localparam logic [7:0] KeyCr     = 8'd13;
  localparam logic [7:0] KeySave   = 8'd15;
  localparam logic [7:0] KeyQuitA  = 8'd24;
  localparam logic [7:0] KeyQuitB  = 8'd27;
  localparam logic [7:0] KeySpace  = 8'd32;
  localparam logic [7:0] KeyDel    = 8'd127;
  localparam logic [7:0] KeyUp     = 8'd128;
  localparam logic [7:0] KeyDown   = 8'd129;
  localparam logic [7:0] KeyLeft   = 8'd130;
  localparam logic [7:0] KeyRight  = 8'd131;

  localparam logic [1:0] ReqNone = 2'd0;
  localparam logic [1:0] ReqSave = 2'd1;
  localparam logic [1:0] ReqQuit = 2'd2;

  // Datapath command: which walk or update to run this cycle.
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdIns, CmdDel, CmdUpBeg, CmdUpPrev, CmdDnBeg, CmdDnEnd,
    CmdDnNext, CmdFinish
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic mem_rd;
  } tbe_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic rd_nl;
  } tbe_stat_t;
endpackage

// File: rtl/text_buffer_edit_engine_top.sv
// Top level of the text buffer edit engine.
// Insert, Backspace, Up and Down walk the store one byte per step, with a wait state after each step.
// One item at a time; the result waits in an output register, and the next
// beat is taken only after the result beat has left.
// Reset clears length, cursor, modified flag and all control state.
module text_buffer_edit_engine_top #(
  parameter int unsigned BufferBytes = tbe_pkg::BufferBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // op[2:0], key_code[10:3], read_index[21:11], load_byte[29:22]
  input  logic [31:0] s_tdata_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // cursor_pos[10:0], text_length[21:11], modified[22], read_data[30:23],
  // request[32:31]
  output logic [39:0] m_tdata_o
);
  import tbe_pkg::*;
  `include "text_buffer_edit_engine_top_macros.svh"

  tbe_cmd_t  cmd;
  tbe_stat_t stat;
  logic busy, done, start, ov_q;
  logic [31:0] in_q;
  logic [10:0] cur, len;
  logic mod;
  logic [7:0] rdat;
  logic [1:0] req;
  logic take;

  // A new beat is taken only when the engine and the output are free.
  assign s_tready_o = !busy && !ov_q && !start;
  assign take = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0; ov_q <= 1'b0;
    end else begin
      start <= take;
      if (done) ov_q <= 1'b1;
      else if (m_tready_i) ov_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) if (take) in_q <= s_tdata_i;

  tbe_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .key_i(in_q[10:3]), .op_i(in_q[2:0]),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy), .done_o(done)
  );

  tbe_dp #(.BufferBytes(BufferBytes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .op_i(in_q[2:0]), .key_i(in_q[10:3]),
    .read_index_i(in_q[21:11]), .load_byte_i(in_q[29:22]), .stat_o(stat),
    .cursor_o(cur), .length_o(len), .modified_o(mod), .read_data_o(rdat),
    .request_o(req)
  );

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {7'd0, req, rdat, mod, len, cur};

  `TBE_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, busy, !s_tready_o)
  `TBE_ASSERT_NXT(a_done_valid, clk_i, rst_ni, done, m_tvalid_o)
endmodule

// File: rtl/tbe_ctrl.sv
// Controller state machine of the text buffer edit engine.
module tbe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [7:0]         key_i,
  input  logic [2:0]         op_i,
  input  tbe_pkg::tbe_stat_t stat_i,
  output tbe_pkg::tbe_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import tbe_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StWalk  = 7'b0000010,
    StWait  = 7'b0000100,
    StStep  = 7'b0001000,
    StStep2 = 7'b0010000,
    StStep3 = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cmd_e   kind_q, kind_d;
  cmd_e   phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= CmdNone;
      phase_q <= CmdNone;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    phase_d = phase_q;
    cmd_o   = '{cmd: CmdNone, mem_rd: 1'b0};
    done_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          // The first cycle loads operands and issues the first read.
          cmd_o = '{cmd: CmdLoad, mem_rd: 1'b1};
          state_d = StWait;
          kind_d  = CmdNone;
          if (op_i == OpKey) begin
            if (key_i == KeyUp) kind_d = CmdUpBeg;
            else if (key_i == KeyDown) kind_d = CmdDnBeg;
            else if (key_i == KeyBs || key_i == KeyDel) kind_d = CmdDel;
            else if (key_i == KeyNl || key_i == KeyCr ||
                     (key_i >= KeySpace && key_i < KeyDel)) kind_d = CmdIns;
          end
          phase_d = kind_d;
        end
      end
      StWait: begin
        // Read data for the current address is now valid.
        state_d = (phase_q == CmdNone) ? StDone : StWalk;
      end
      StWalk: begin
        cmd_o = '{cmd: phase_q, mem_rd: 1'b1};
        if (stat_i.walk_done) begin
          case (phase_q)
            CmdUpBeg: begin phase_d = CmdUpPrev; state_d = StWait; end
            CmdDnBeg: begin phase_d = CmdDnEnd; state_d = StWait; end
            CmdDnEnd: begin phase_d = CmdDnNext; state_d = StWait; end
            default:  begin phase_d = CmdNone; state_d = StDone; end
          endcase
        end else begin
          state_d = StWait;
        end
      end
      StDone: begin
        cmd_o  = '{cmd: CmdFinish, mem_rd: 1'b0};
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
endmodule

// File: rtl/tbe_dp.sv
// Datapath of the text buffer edit engine: store, pointers and walks.
module tbe_dp #(
  parameter int unsigned BufferBytes = tbe_pkg::BufferBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbe_pkg::tbe_cmd_t cmd_i,
  input  logic [2:0]        op_i,
  input  logic [7:0]        key_i,
  input  logic [10:0]       read_index_i,
  input  logic [7:0]        load_byte_i,
  output tbe_pkg::tbe_stat_t stat_o,
  output logic [10:0]       cursor_o,
  output logic [10:0]       length_o,
  output logic              modified_o,
  output logic [7:0]        read_data_o,
  output logic [1:0]        request_o
);
  import tbe_pkg::*;

  localparam int unsigned AW = $clog2(BufferBytes);
  localparam logic [AW:0] Full = (AW+1)'(BufferBytes - 1);

  logic [7:0] mem [BufferBytes];
  logic [7:0] rdata_q;
  logic [AW-1:0] raddr;
  logic       we;
  logic [AW-1:0] waddr;
  logic [7:0] wdata;

  logic [AW:0] len_q, len_d, cur_q, cur_d, p_q, p_d, a_q, a_d, col_q, col_d;
  logic [AW:0] n_q, n_d;
  logic        dirty_q, dirty_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  rd_q, rd_d;
  logic [1:0]  req_q, req_d;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.mem_rd) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; cur_q <= '0; dirty_q <= 1'b0;
    end else begin
      len_q <= len_d; cur_q <= cur_d; dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; a_q <= a_d; col_q <= col_d; n_q <= n_d;
    byte_q <= byte_d; rd_q <= rd_d; req_q <= req_d;
  end

  logic nl;
  assign nl = (rdata_q == KeyNl);

  always_comb begin
    len_d = len_q; cur_d = cur_q; dirty_d = dirty_q;
    p_d = p_q; a_d = a_q; col_d = col_q; n_d = n_q;
    byte_d = byte_q; rd_d = rd_q; req_d = req_q;
    we = 1'b0; waddr = p_q[AW-1:0]; wdata = rdata_q;
    raddr = p_q[AW-1:0];
    stat_o = '{walk_done: 1'b0, rd_nl: nl};
    case (cmd_i.cmd)
      CmdLoad: begin
        rd_d = '0; req_d = ReqNone;
        byte_d = (key_i == KeyCr) ? KeyNl : key_i;
        case (op_i)
          OpKey: begin
            if (key_i == KeyQuitA || key_i == KeyQuitB) req_d = ReqQuit;
            else if (key_i == KeySave) req_d = ReqSave;
            else if (key_i == KeyRight) begin
              if (cur_q < len_q) cur_d = cur_q + 1'b1;
            end else if (key_i == KeyLeft) begin
              if (cur_q != '0) cur_d = cur_q - 1'b1;
            end
          end
          OpClear: begin len_d = '0; cur_d = '0; dirty_d = 1'b0; end
          OpAppend: begin
            if (len_q < Full) begin
              we = 1'b1; waddr = len_q[AW-1:0]; wdata = load_byte_i;
              len_d = len_q + 1'b1;
            end
          end
          OpSaved: dirty_d = 1'b0;
          default: ;
        endcase
        // Walk start points.
        if (op_i == OpRead) begin
          p_d = (AW+1)'(read_index_i);
        end else if (key_i == KeyBs || key_i == KeyDel) begin
          p_d = cur_q;
        end else if (key_i == KeyUp || key_i == KeyDown) begin
          p_d = (cur_q == '0) ? '0 : cur_q - 1'b1;
        end else begin
          p_d = (len_q == '0) ? '0 : len_q - 1'b1;
        end
        a_d = cur_q;
        raddr = p_d[AW-1:0];
      end
      CmdIns: begin
        // Shift the tail up one byte per step, then drop the new byte in.
        if (len_q >= Full) stat_o.walk_done = 1'b1;
        else if (p_q + 1'b1 > cur_q && len_q != '0 && p_q < len_q &&
                 !(p_q == cur_q - 1'b1 && cur_q == '0)) begin
          if (p_q >= cur_q) begin
            we = 1'b1; waddr = AW'(p_q + 1'b1); wdata = rdata_q;
          end
          if (p_q <= cur_q) begin
            stat_o.walk_done = 1'b1;
            if (p_q == cur_q) begin
              we = 1'b1; waddr = AW'(p_q + 1'b1); wdata = rdata_q;
            end
          end else begin
            p_d = p_q - 1'b1; raddr = p_d[AW-1:0];
          end
        end else stat_o.walk_done = 1'b1;
        if (stat_o.walk_done && len_q < Full) begin
          // Write of the new byte happens at Finish to avoid a port clash.
          n_d = '1;
        end else n_d = '0;
      end
      CmdDel: begin
        if (cur_q == '0) stat_o.walk_done = 1'b1;
        else if (p_q < len_q) begin
          we = 1'b1; waddr = AW'(p_q - 1'b1); wdata = rdata_q;
          p_d = p_q + 1'b1; raddr = p_d[AW-1:0];
        end else begin
          stat_o.walk_done = 1'b1;
          len_d = len_q - 1'b1; cur_d = cur_q - 1'b1; dirty_d = 1'b1;
        end
      end
      CmdUpBeg: begin
        // Find start of the cursor line: a_q ends as line begin.
        if (a_q != '0 && !nl) begin
          a_d = a_q - 1'b1; p_d = a_d - 1'b1; raddr = p_d[AW-1:0];
        end else begin
          stat_o.walk_done = 1'b1;
          col_d = cur_q - a_q;
          n_d = a_q;
          if (a_q != '0) begin
            a_d = a_q - 1'b1;
            p_d = (a_d == '0) ? '0 : a_d - 1'b1; raddr = p_d[AW-1:0];
          end
        end
      end
      CmdUpPrev: begin
        if (n_q == '0) stat_o.walk_done = 1'b1;
        else if (a_q != '0 && !nl) begin
          a_d = a_q - 1'b1; p_d = a_d - 1'b1; raddr = p_d[AW-1:0];
        end else begin
          stat_o.walk_done = 1'b1;
          cur_d = a_q + ((col_q > (n_q - 1'b1 - a_q)) ? (n_q - 1'b1 - a_q) : col_q);
        end
      end
      CmdDnBeg: begin
        if (a_q != '0 && !nl) begin
          a_d = a_q - 1'b1; p_d = a_d - 1'b1; raddr = p_d[AW-1:0];
        end else begin
          stat_o.walk_done = 1'b1;
          col_d = cur_q - a_q;
          p_d = cur_q; raddr = p_d[AW-1:0];
        end
      end
      CmdDnEnd: begin
        if (p_q < len_q && !nl) begin
          p_d = p_q + 1'b1; raddr = p_d[AW-1:0];
        end else begin
          stat_o.walk_done = 1'b1;
          n_d = '0;
          if (p_q >= len_q) a_d = '1;
          else a_d = p_q + 1'b1;
          p_d = p_q + 1'b1; raddr = p_d[AW-1:0];
        end
      end
      CmdDnNext: begin
        if (a_q == '1) stat_o.walk_done = 1'b1;
        else if (p_q < len_q && !nl) begin
          p_d = p_q + 1'b1; n_d = n_q + 1'b1; raddr = p_d[AW-1:0];
        end else begin
          stat_o.walk_done = 1'b1;
          cur_d = a_q + ((col_q > n_q) ? n_q : col_q);
        end
      end
      CmdFinish: begin
        if (op_i == OpRead && 32'(read_index_i) < 32'(len_q)) rd_d = rdata_q;
        if (op_i == OpKey && n_q == '1 && len_q < Full &&
            (key_i == KeyNl || key_i == KeyCr ||
             (key_i >= KeySpace && key_i < KeyDel))) begin
          we = 1'b1; waddr = cur_q[AW-1:0]; wdata = byte_q;
          len_d = len_q + 1'b1; cur_d = cur_q + 1'b1; dirty_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cursor_o    = 11'(cur_q);
  assign length_o    = 11'(len_q);
  assign modified_o  = dirty_q;
  assign read_data_o = rd_q;
  assign request_o   = req_q;
endmodule

// File: sim/text_buffer_edit_engine_checker.sv
// Checker that predicts and compares the results of the text buffer edit engine.
module text_buffer_edit_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tbe_pkg::*;

  localparam int unsigned Cap = BufferBytesDefault;

  logic [7:0]  shadow_text [Cap];
  int unsigned shadow_len;
  int unsigned shadow_cur;
  logic        shadow_dirty;
  logic [39:0] expected_beats [$];

  function automatic int unsigned line_start(int unsigned at);
    while (at > 0 && shadow_text[at-1] != KeyNl) at--;
    return at;
  endfunction

  task automatic insert_byte(logic [7:0] b);
    if (shadow_len >= Cap - 1) return;
    for (int unsigned i = shadow_len; i > shadow_cur; i--) shadow_text[i] = shadow_text[i-1];
    shadow_text[shadow_cur] = b;
    shadow_len++;
    shadow_cur++;
    shadow_dirty = 1'b1;
  endtask

  task automatic apply_key(logic [7:0] k, output logic [1:0] req);
    int unsigned here, col, prev, plen, p, nxt, nlen;
    req = ReqNone;
    if (k == KeyQuitA || k == KeyQuitB) req = ReqQuit;
    else if (k == KeySave) req = ReqSave;
    else if (k == KeyRight) begin
      if (shadow_cur < shadow_len) shadow_cur++;
    end else if (k == KeyLeft) begin
      if (shadow_cur > 0) shadow_cur--;
    end else if (k == KeyUp) begin
      here = line_start(shadow_cur);
      col = shadow_cur - here;
      if (here != 0) begin
        prev = line_start(here - 1);
        plen = here - 1 - prev;
        if (col > plen) col = plen;
        shadow_cur = prev + col;
      end
    end else if (k == KeyDown) begin
      col = shadow_cur - line_start(shadow_cur);
      p = shadow_cur;
      while (p < shadow_len && shadow_text[p] != KeyNl) p++;
      if (p < shadow_len) begin
        nxt = p + 1;
        p = nxt;
        nlen = 0;
        while (p < shadow_len && shadow_text[p] != KeyNl) begin
          p++;
          nlen++;
        end
        if (col > nlen) col = nlen;
        shadow_cur = nxt + col;
      end
    end else if (k == KeyBs || k == KeyDel) begin
      if (shadow_cur != 0) begin
        for (int unsigned i = shadow_cur; i < shadow_len; i++) shadow_text[i-1] = shadow_text[i];
        shadow_len--;
        shadow_cur--;
        shadow_dirty = 1'b1;
      end
    end else if (k == KeyCr || k == KeyNl) insert_byte(KeyNl);
    else if (k >= KeySpace && k < KeyDel) insert_byte(k);
  endtask

  task automatic predict_edit(logic [31:0] beat);
    logic [2:0]  op;
    logic [10:0] idx;
    logic [7:0]  rdata;
    logic [1:0]  req;
    op = beat[2:0];
    idx = beat[21:11];
    rdata = '0;
    req = ReqNone;
    case (op)
      OpKey: apply_key(beat[10:3], req);
      OpRead: if (idx < shadow_len) rdata = shadow_text[idx];
      OpClear: begin
        shadow_len = 0;
        shadow_cur = 0;
        shadow_dirty = 1'b0;
      end
      OpAppend: if (shadow_len < Cap - 1) begin
        shadow_text[shadow_len] = beat[29:22];
        shadow_len++;
      end
      OpSaved: shadow_dirty = 1'b0;
      default: ;
    endcase
    expected_beats.push_back({7'd0, req, rdata, shadow_dirty, shadow_len[10:0],
                              shadow_cur[10:0]});
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    logic [39:0] want;
    if (!rst_ni) begin
      shadow_len = 0;
      shadow_cur = 0;
      shadow_dirty = 1'b0;
      expected_beats.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) predict_edit(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (expected_beats.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          want = expected_beats.pop_front();
          if (m_tdata_i[10:0] != want[10:0])
            report_mismatch("cursor_pos", m_tdata_i[10:0], want[10:0]);
          if (m_tdata_i[21:11] != want[21:11])
            report_mismatch("text_length", m_tdata_i[21:11], want[21:11]);
          if (m_tdata_i[22] != want[22]) report_mismatch("modified", m_tdata_i[22], want[22]);
          if (m_tdata_i[30:23] != want[30:23])
            report_mismatch("read_data", m_tdata_i[30:23], want[30:23]);
          if (m_tdata_i[32:31] != want[32:31])
            report_mismatch("request", m_tdata_i[32:31], want[32:31]);
        end
      end
    end
    pending_o = expected_beats.size();
  end
endmodule

// File: sim/text_buffer_edit_engine_top_tb.sv
// Testbench top that drives edit requests into the text buffer edit engine.
module text_buffer_edit_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbe_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          fail_count;
  int          pending;
  bit          quiet_tail = 1'b0;

  always #4 clk_i = ~clk_i;

  text_buffer_edit_engine_top u_dut (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata)
  );

  text_buffer_edit_engine_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Sends one request beat, with an occasional idle burst ahead of it. All
  // drives happen on the falling edge; valid stays high until the beat is taken.
  task automatic send_edit(logic [2:0] op, logic [7:0] key, logic [10:0] idx,
                           logic [7:0] lb);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_tdata = {2'b00, lb, idx, key, op};
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  task automatic press(logic [7:0] key);
    send_edit(OpKey, key, 11'($urandom), 8'($urandom));
  endtask

  // The receiver stalls in random bursts, except in the final stretch.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end else m_tready <= 1'b1;
    end
  end

  // Picks a key biased toward editing and navigation, so lines actually form.
  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 11))
      0, 1, 2: return 8'($urandom_range(32, 126));
      3:       return ($urandom_range(0, 1) != 0) ? KeyNl : KeyCr;
      4:       return ($urandom_range(0, 1) != 0) ? KeyBs : KeyDel;
      5:       return KeyUp;
      6:       return KeyDown;
      7:       return KeyLeft;
      8:       return KeyRight;
      9:       return ($urandom_range(0, 2) == 0) ? KeySave : KeyQuitA;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: edge keys on an empty store, then a short two line text.
    press(KeyBs);
    press(KeyLeft);
    press(KeyRight);
    press(KeyUp);
    press(KeyDown);
    press(8'h41);
    press(8'h7e);
    press(KeyCr);
    press(8'h20);
    press(KeyUp);
    press(KeyDown);
    press(KeyDown);
    press(KeySave);
    press(KeyQuitA);
    press(KeyQuitB);
    press(8'hff);
    press(8'h00);
    send_edit(OpRead, 8'hff, 11'd0, 8'hff);
    send_edit(OpRead, 8'h00, 11'h7ff, 8'h00);
    send_edit(OpAppend, 8'h00, 11'd0, 8'hff);
    send_edit(OpSaved, 8'h00, 11'd0, 8'h00);
    send_edit(3'd5, 8'h00, 11'd0, 8'h00);
    send_edit(3'd7, 8'hff, 11'h7ff, 8'hff);
    press(KeyDel);
    send_edit(OpClear, 8'h00, 11'd0, 8'h00);

    // Let every outstanding result drain before the random part.
    while (pending != 0) @(negedge clk_i);

    for (int n = 0; n < 254; n++) begin
      if (n > 214) quiet_tail = 1'b1;
      case ($urandom_range(0, 19))
        0:       op = OpRead;
        1:       op = OpAppend;
        2:       op = ($urandom_range(0, 3) == 0) ? OpClear : OpSaved;
        3:       op = 3'($urandom_range(5, 7));
        default: op = OpKey;
      endcase
      send_edit(op, pick_key(), 11'($urandom_range(0, 40)) | (($urandom_range(0, 9) == 0) ?
                11'($urandom) : 11'd0), ($urandom_range(0, 2) == 0) ? KeyNl : 8'($urandom));
    end

    // A short closing sequence of edits, reads and navigation.
    send_edit(OpClear, 8'h00, 11'd0, 8'h00);
    press(8'h5a);
    send_edit(OpAppend, 8'h00, 11'd0, 8'h11);
    send_edit(OpRead, 8'h00, 11'd2046, 8'h00);
    send_edit(OpRead, 8'h00, 11'd2047, 8'h00);
    press(KeyDown);
    press(KeyUp);
    press(KeyBs);
    press(KeyRight);
    send_edit(OpClear, 8'h00, 11'd0, 8'h00);

    while (pending != 0) @(negedge clk_i);
    repeat (4200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("text_buffer_edit_engine_top_tb passed");
    else $display("text_buffer_edit_engine_top_tb failed");
    $finish;
  end

  // Watchdog: generous even if every walk spans the whole store.
  initial begin
    #60ms;
    $display("text_buffer_edit_engine_top_tb failed");
    $finish;
  end
endmodule

// File: text_buffer_edit_engine_top.f
+incdir+rtl
rtl/tbe_pkg.sv
rtl/tbe_ctrl.sv
rtl/tbe_dp.sv
rtl/text_buffer_edit_engine_top.sv
sim/text_buffer_edit_engine_checker.sv
sim/text_buffer_edit_engine_top_tb.sv
